/* hdl/dpp_pkg.sv */
// Shared types, codes and lookup functions of the DHCP message parser.
`default_nettype none

package dpp_pkg;

	// field codes of a result word
	localparam logic [4:0] FC_OP      = 5'd0;
	localparam logic [4:0] FC_HTYPE   = 5'd1;
	localparam logic [4:0] FC_HLEN    = 5'd2;
	localparam logic [4:0] FC_HOPS    = 5'd3;
	localparam logic [4:0] FC_XID     = 5'd4;
	localparam logic [4:0] FC_SECS    = 5'd5;
	localparam logic [4:0] FC_FLAGS   = 5'd6;
	localparam logic [4:0] FC_CIADDR  = 5'd7;
	localparam logic [4:0] FC_YIADDR  = 5'd8;
	localparam logic [4:0] FC_SIADDR  = 5'd9;
	localparam logic [4:0] FC_GIADDR  = 5'd10;
	localparam logic [4:0] FC_CHADDR  = 5'd11;
	localparam logic [4:0] FC_MSGTYPE = 5'd12;
	localparam logic [4:0] FC_LEASE   = 5'd13;
	localparam logic [4:0] FC_MASK    = 5'd14;
	localparam logic [4:0] FC_SERVER  = 5'd15;
	localparam logic [4:0] FC_STATUS  = 5'd16;

	// parse status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT_HDR = 3'd1;
	localparam logic [2:0] ST_BAD_COOKIE = 3'd2;
	localparam logic [2:0] ST_OPT_SIZE  = 3'd3;
	localparam logic [2:0] ST_OPT_TRUNC = 3'd4;
	localparam logic [2:0] ST_NO_END    = 3'd5;

	// option codes
	localparam logic [7:0] OPT_PAD     = 8'd0;
	localparam logic [7:0] OPT_MASK    = 8'd1;
	localparam logic [7:0] OPT_LEASE   = 8'd51;
	localparam logic [7:0] OPT_MSGTYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER  = 8'd54;
	localparam logic [7:0] OPT_END     = 8'd255;

	// message layout
	localparam int HDR_DECODE_END = 34;   // first byte past the client MAC
	localparam int HDR_BYTES      = 236;
	localparam int COOKIE_BYTES   = 4;

	typedef enum logic [6:0] {
		PH_HEADER   = 7'b0000001,
		PH_COOKIE   = 7'b0000010,
		PH_OPT_CODE = 7'b0000100,
		PH_OPT_LEN  = 7'b0001000,
		PH_OPT_DATA = 7'b0010000,
		PH_DONE     = 7'b0100000,
		PH_ERROR    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [4:0]  code;
		logic [47:0] value;
		logic [2:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] code;
	} hdr_hit_t;

	// header field that ends at this byte offset, if any
	function automatic hdr_hit_t hdr_field(input logic [5:0] p);
		hdr_hit_t h;
		h.hit  = 1'b1;
		h.code = FC_OP;
		case (p)
			6'd0:  h.code = FC_OP;
			6'd1:  h.code = FC_HTYPE;
			6'd2:  h.code = FC_HLEN;
			6'd3:  h.code = FC_HOPS;
			6'd7:  h.code = FC_XID;
			6'd9:  h.code = FC_SECS;
			6'd11: h.code = FC_FLAGS;
			6'd15: h.code = FC_CIADDR;
			6'd19: h.code = FC_YIADDR;
			6'd23: h.code = FC_SIADDR;
			6'd27: h.code = FC_GIADDR;
			6'd33: h.code = FC_CHADDR;
			default: h.hit = 1'b0;
		endcase
		return h;
	endfunction

	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'd99;
			2'd1: c = 8'd130;
			2'd2: c = 8'd83;
			default: c = 8'd99;
		endcase
		return c;
	endfunction

	// fixed length of a decoded option, zero for options that are skipped
	function automatic logic [2:0] known_size(input logic [7:0] code);
		logic [2:0] s;
		case (code)
			OPT_MSGTYPE: s = 3'd1;
			OPT_LEASE:   s = 3'd4;
			OPT_MASK:    s = 3'd4;
			OPT_SERVER:  s = 3'd4;
			default:     s = 3'd0;
		endcase
		return s;
	endfunction

	// field code of a decoded option, zero for options that are skipped
	function automatic logic [4:0] option_field(input logic [7:0] code);
		logic [4:0] f;
		case (code)
			OPT_MSGTYPE: f = FC_MSGTYPE;
			OPT_LEASE:   f = FC_LEASE;
			OPT_MASK:    f = FC_MASK;
			OPT_SERVER:  f = FC_SERVER;
			default:     f = FC_OP;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

/* hdl/dhcp_packet_parser.sv */
// DHCP message parser: byte-wide header, cookie and option decoder with a result queue.
// An accepted word waits in the input register; when the queue has two free slots, its
//   results enter the four-entry queue and are offered on the output from then on.
// Throughput: one byte per cycle while the queue has two free slots; a final byte that
//   also completes a field yields two words, which the single output port drains in turn.
// Reset: arst_n clears parse state, the input register valid and the queue at once.
`default_nettype none

module dhcp_packet_parser #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_packet,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       field_code,
	output logic [47:0]      field_value,
	output logic [2:0]       parse_status,
	output logic             last
);
	import dpp_pkg::*;

	localparam int PW = $clog2(MAX_PACKET_BYTES);
	localparam logic [PW-1:0] POS_MAX     = PW'(MAX_PACKET_BYTES - 1);
	localparam logic [PW-1:0] POS_DEC_END = PW'(HDR_DECODE_END);
	localparam logic [PW-1:0] POS_HDR_END = PW'(HDR_BYTES - 1);
	localparam logic [PW-1:0] POS_CK_END  = PW'(HDR_BYTES + COOKIE_BYTES - 1);

	// input register
	logic       vld_s1;
	logic [7:0] data_s1;
	logic       eop_s1;

	// parse state
	phase_t        ph_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    ocode_q;
	logic [7:0]    left_q;
	logic [47:0]   acc_q;
	logic [2:0]    err_q;

	// result queue
	result_t    fifo_q [4];
	logic [1:0] rd_q;
	logic [1:0] wr_q;
	logic [2:0] cnt_q;

	logic    room;
	logic    fire;
	logic    pop;

	phase_t        ph_d;
	logic [PW-1:0] pos_d;
	logic [7:0]    ocode_d;
	logic [7:0]    left_d;
	logic [47:0]   acc_d;
	logic [2:0]    err_d;
	result_t       res0;
	result_t       res1;
	logic [1:0]    nres;

	logic [47:0] acc_shift;
	hdr_hit_t    hh;
	logic [2:0]  sz;
	logic [4:0]  ofc;
	logic [2:0]  st;

	// take a new word when the register is empty or its word moves on this cycle;
	// the queue must hold two free slots before a word is processed
	assign room     = (cnt_q <= 3'd2);
	assign fire     = vld_s1 && room;
	assign in_ready = !vld_s1 || room;
	assign pop      = out_valid && out_ready;

	assign acc_shift = {acc_q[39:0], data_s1};
	assign hh        = hdr_field(pos_q[5:0]);
	assign sz        = known_size(ocode_q);
	assign ofc       = option_field(ocode_q);

	always_comb begin
		ph_d    = ph_q;
		pos_d   = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
		ocode_d = ocode_q;
		left_d  = left_q;
		acc_d   = acc_q;
		err_d   = err_q;
		res0    = '0;
		res1    = '0;
		nres    = 2'd0;
		st      = ST_OK;

		case (ph_q)
			PH_HEADER: begin
				// shift in the header bytes up to the client MAC, emit on field boundaries
				if (pos_q < POS_DEC_END) begin
					acc_d = acc_shift;
					if (hh.hit) begin
						res0  = '{code: hh.code, value: acc_shift, status: ST_OK, last: 1'b0};
						nres  = 2'd1;
						acc_d = '0;
					end
				end
				if (pos_q >= POS_HDR_END) begin
					ph_d = PH_COOKIE;
				end
			end
			PH_COOKIE: begin
				if (data_s1 != cookie_byte(pos_q[1:0])) begin
					err_d = ST_BAD_COOKIE;
				end
				if (pos_q >= POS_CK_END) begin
					ph_d = (err_d != ST_OK) ? PH_ERROR : PH_OPT_CODE;
				end
			end
			PH_OPT_CODE: begin
				// pad bytes advance one at a time and keep this phase
				if (data_s1 == OPT_END) begin
					ph_d = PH_DONE;
				end else if (data_s1 != OPT_PAD) begin
					ocode_d = data_s1;
					ph_d    = PH_OPT_LEN;
				end
			end
			PH_OPT_LEN: begin
				if (sz != 3'd0 && data_s1 != {5'd0, sz}) begin
					err_d = ST_OPT_SIZE;
					ph_d  = PH_ERROR;
				end else if (data_s1 == 8'd0) begin
					ph_d = PH_OPT_CODE;
				end else begin
					left_d = data_s1;
					acc_d  = '0;
					ph_d   = PH_OPT_DATA;
				end
			end
			PH_OPT_DATA: begin
				acc_d  = acc_shift;
				left_d = left_q - 8'd1;
				if (left_d == 8'd0) begin
					if (ofc != FC_OP) begin
						res0 = '{code: ofc, value: acc_shift, status: ST_OK, last: 1'b0};
						nres = 2'd1;
					end
					acc_d = '0;
					ph_d  = PH_OPT_CODE;
				end
			end
			default: begin
			end
		endcase

		if (eop_s1) begin
			// status follows the phase reached after this byte
			case (ph_d)
				PH_HEADER:   st = ST_SHORT_HDR;
				PH_OPT_CODE: st = ST_NO_END;
				PH_OPT_LEN:  st = ST_OPT_TRUNC;
				PH_OPT_DATA: st = ST_OPT_TRUNC;
				PH_ERROR:    st = err_d;
				default:     st = ST_OK;
			endcase
			if (nres == 2'd0) begin
				res0 = '{code: FC_STATUS, value: 48'd0, status: st, last: 1'b1};
			end else begin
				res1 = '{code: FC_STATUS, value: 48'd0, status: st, last: 1'b1};
			end
			nres    = nres + 2'd1;
			// drop all packet state for the next message
			ph_d    = PH_HEADER;
			pos_d   = '0;
			ocode_d = '0;
			left_d  = '0;
			acc_d   = '0;
			err_d   = ST_OK;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eop_s1  <= end_of_packet;
		end
	end

	// parse state: advance once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_HEADER;
			pos_q   <= '0;
			ocode_q <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			err_q   <= ST_OK;
		end else if (fire) begin
			ph_q    <= ph_d;
			pos_q   <= pos_d;
			ocode_q <= ocode_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			err_q   <= err_d;
		end
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			if (fire) begin
				wr_q <= wr_q + nres;
			end
			cnt_q <= cnt_q + (fire ? {1'b0, nres} : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (fire && nres != 2'd0) begin
			fifo_q[wr_q] <= res0;
		end
		if (fire && nres == 2'd2) begin
			fifo_q[wr_q + 2'd1] <= res1;
		end
	end

	// hold the head word on the output until taken
	assign out_valid    = (cnt_q != 3'd0);
	assign field_code   = fifo_q[rd_q].code;
	assign field_value  = fifo_q[rd_q].value;
	assign parse_status = fifo_q[rd_q].status;
	assign last         = fifo_q[rd_q].last;

endmodule

`default_nettype wire

/* bench/dpp_bench_pkg.sv */
// Bench constants and the field scoreboard of the DHCP message parser bench.
package dpp_bench_pkg;

	import dpp_pkg::*;

	localparam int PACKET_LIMIT = 2048;

	localparam logic [31:0] COOKIE_MAGIC = {8'd99, 8'd130, 8'd83, 8'd99};

	// length that a decoded option must carry, zero for skipped options
	function automatic int decoded_length(input logic [7:0] code);
		case (code)
			OPT_MSGTYPE: return 1;
			OPT_LEASE, OPT_MASK, OPT_SERVER: return 4;
			default: return 0;
		endcase
	endfunction

	class parse_board;
		phase_t      phase;
		logic [10:0] position;
		logic [7:0]  opt_code;
		logic [7:0]  opt_left;
		logic [47:0] acc;
		logic [2:0]  err;
		result_t     due_q[$];
		int          mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			phase    = PH_HEADER;
			position = '0;
			opt_code = '0;
			opt_left = '0;
			acc      = '0;
			err      = ST_OK;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void queue_result(input logic [4:0] code, input logic [47:0] value,
				input logic [2:0] status, input logic fin);
			result_t r;
			r.code   = code;
			r.value  = value;
			r.status = status;
			r.last   = fin;
			due_q.push_back(r);
		endfunction

		// advance the parse by one accepted word and queue what it yields
		function void note_word(input logic [7:0] b, input logic eop);
			logic [4:0] hdr_code;
			logic       hdr_hit;
			logic [7:0] want;
			logic [2:0] st;
			int         idx;
			int         size;
			case (phase)
				PH_HEADER: begin
					if (position < HDR_DECODE_END) begin
						acc = {acc[39:0], b};
						hdr_hit = 1'b1;
						hdr_code = FC_OP;
						case (position)
							0:  hdr_code = FC_OP;
							1:  hdr_code = FC_HTYPE;
							2:  hdr_code = FC_HLEN;
							3:  hdr_code = FC_HOPS;
							7:  hdr_code = FC_XID;
							9:  hdr_code = FC_SECS;
							11: hdr_code = FC_FLAGS;
							15: hdr_code = FC_CIADDR;
							19: hdr_code = FC_YIADDR;
							23: hdr_code = FC_SIADDR;
							27: hdr_code = FC_GIADDR;
							33: hdr_code = FC_CHADDR;
							default: hdr_hit = 1'b0;
						endcase
						if (hdr_hit) begin
							queue_result(hdr_code, acc, ST_OK, 1'b0);
							acc = '0;
						end
					end
					if (position >= HDR_BYTES - 1)
						phase = PH_COOKIE;
				end
				PH_COOKIE: begin
					idx = (int'(position) - HDR_BYTES) & 3;
					want = COOKIE_MAGIC[31 - 8 * idx -: 8];
					if (b != want)
						err = ST_BAD_COOKIE;
					if (position >= HDR_BYTES + COOKIE_BYTES - 1)
						phase = (err != ST_OK) ? PH_ERROR : PH_OPT_CODE;
				end
				PH_OPT_CODE: begin
					if (b == OPT_END) begin
						phase = PH_DONE;
					end else if (b != OPT_PAD) begin
						opt_code = b;
						phase = PH_OPT_LEN;
					end
				end
				PH_OPT_LEN: begin
					size = decoded_length(opt_code);
					if (size != 0 && int'(b) != size) begin
						err = ST_OPT_SIZE;
						phase = PH_ERROR;
					end else if (b == 8'd0) begin
						phase = PH_OPT_CODE;
					end else begin
						opt_left = b;
						acc = '0;
						phase = PH_OPT_DATA;
					end
				end
				PH_OPT_DATA: begin
					acc = {acc[39:0], b};
					opt_left = opt_left - 8'd1;
					if (opt_left == 8'd0) begin
						case (opt_code)
							OPT_MSGTYPE: queue_result(FC_MSGTYPE, acc, ST_OK, 1'b0);
							OPT_LEASE:   queue_result(FC_LEASE, acc, ST_OK, 1'b0);
							OPT_MASK:    queue_result(FC_MASK, acc, ST_OK, 1'b0);
							OPT_SERVER:  queue_result(FC_SERVER, acc, ST_OK, 1'b0);
							default: ;
						endcase
						acc = '0;
						phase = PH_OPT_CODE;
					end
				end
				default: ;
			endcase
			if (position < PACKET_LIMIT - 1)
				position = position + 11'd1;
			if (eop) begin
				case (phase)
					PH_HEADER:   st = ST_SHORT_HDR;
					PH_COOKIE:   st = ST_OK;
					PH_OPT_CODE: st = ST_NO_END;
					PH_OPT_LEN:  st = ST_OPT_TRUNC;
					PH_OPT_DATA: st = ST_OPT_TRUNC;
					PH_ERROR:    st = err;
					default:     st = ST_OK;
				endcase
				queue_result(FC_STATUS, '0, st, 1'b1);
				restart();
			end
		endfunction

		task report(input string what);
			mismatches++;
			$display("mismatch %0d: %s", mismatches, what);
		endtask

		task check_result(input result_t got);
			result_t want;
			if (due_q.size() == 0) begin
				report($sformatf("unexpected word code %0d value %h status %0d last %0d",
					got.code, got.value, got.status, got.last));
				return;
			end
			want = due_q.pop_front();
			if (got.code !== want.code || got.value !== want.value ||
					got.status !== want.status || got.last !== want.last)
				report($sformatf("got code %0d value %h status %0d last %0d, want %0d %h %0d %0d",
					got.code, got.value, got.status, got.last,
					want.code, want.value, want.status, want.last));
		endtask
	endclass

endpackage

/* bench/dhcp_packet_parser_test.sv */
// Top of the DHCP message parser bench: clock, reset, message stimulus and result checking.
module dhcp_packet_parser_test;

	timeunit 1ns;
	timeprecision 1ps;

	import dpp_pkg::*;
	import dpp_bench_pkg::*;

	// generous ceiling: a few thousand messages bytes, each with worst idling on both sides
	localparam int CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        end_of_packet = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  field_code;
	logic [47:0] field_value;
	logic [2:0]  parse_status;
	logic        last;

	parse_board board = new();

	// message under construction, sent byte by byte in wire order
	logic [7:0] packet_bytes[$];

	int  bytes_sent = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  recv_hold = 0;
	int  cycle_count = 0;
	bit  quiet = 1'b0;

	dhcp_packet_parser #(.MAX_PACKET_BYTES(PACKET_LIMIT)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.field_code    (field_code),
		.field_value   (field_value),
		.parse_status  (parse_status),
		.last          (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[dhcp_packet_parser] ERROR");
			$finish;
		end
	end

	// Result side: check each word taken at this edge against the oldest prediction,
	// then decide the ready level for the next edge. Stalls come in random bursts.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result({field_code, field_value, parse_status, last});
		if (recv_hold != 0) begin
			recv_hold--;
			out_ready <= 1'b0;
		end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
			recv_hold = $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// pick an idling rate per message: none, light or heavy
	function automatic int idle_choice();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	function automatic logic [7:0] pick_decoded_code();
		case ($urandom_range(0, 3))
			0: return OPT_MSGTYPE;
			1: return OPT_LEASE;
			2: return OPT_MASK;
			default: return OPT_SERVER;
		endcase
	endfunction

	// start a message with the 236-byte fixed header
	function automatic void begin_message(input bit random_fill, input logic [7:0] fill);
		packet_bytes = {};
		for (int i = 0; i < HDR_BYTES; i++)
			packet_bytes.push_back(random_fill ? 8'($urandom) : fill);
	endfunction

	// append the magic cookie; spoil_at picks a byte to corrupt, negative for none
	function automatic void add_cookie(input int spoil_at);
		logic [7:0] c;
		for (int i = 0; i < COOKIE_BYTES; i++) begin
			c = COOKIE_MAGIC[31 - 8 * i -: 8];
			if (i == spoil_at)
				c = c ^ 8'($urandom_range(1, 255));
			packet_bytes.push_back(c);
		end
	endfunction

	// append one TLV option; fill is the data byte value, negative for random data
	function automatic void add_option(input logic [7:0] code, input int len, input int fill);
		packet_bytes.push_back(code);
		packet_bytes.push_back(8'(len));
		for (int i = 0; i < len; i++)
			packet_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
	endfunction

	// append well-formed options: pads, decoded options and skipped options
	function automatic void add_random_options(input int count);
		logic [7:0] code;
		int         r;
		int         len;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				packet_bytes.push_back(OPT_PAD);
			end else if (r < 50) begin
				code = pick_decoded_code();
				add_option(code, decoded_length(code), -1);
			end else begin
				code = 8'($urandom_range(2, 254));
				len = decoded_length(code);
				if (len == 0)
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
				add_option(code, len, -1);
			end
		end
	endfunction

	// Offer one word and hold it until taken. An idle burst, if any, comes first;
	// valid is raised again only on a later edge, never in the step that lowered it.
	task automatic send_word(input logic [7:0] b, input logic eop);
		int gap;
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_packet <= eop;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_word(b, eop);
		bytes_sent++;
	endtask

	// send the message held in packet_bytes, flagging its final byte
	task automatic send_packet();
		int n;
		n = packet_bytes.size();
		if (!quiet) begin
			send_idle_pct = idle_choice();
			recv_idle_pct = idle_choice();
		end
		for (int i = 0; i < n; i++)
			send_word(packet_bytes[i], i == n - 1);
	endtask

	// hold off input until every predicted word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int kind;
		int cut;
		int run_start;
		int deep_packets;
		int spoil;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone byte: op field, then short header
		packet_bytes = {8'hFF};
		send_packet();

		// all-zero header cut in the middle
		begin_message(1'b0, 8'h00);
		packet_bytes = packet_bytes[0:99];
		send_packet();

		// all-ones header ending on its last byte: already in the cookie, so ok
		begin_message(1'b0, 8'hFF);
		send_packet();

		// end inside the cookie after a bad cookie byte: cookie not judged
		begin_message(1'b1, 8'h00);
		add_cookie(1);
		packet_bytes = packet_bytes[0:237];
		send_packet();

		// header plus cookie and nothing else: no end option
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		send_packet();

		// bad cookie reported right at the end of the cookie
		begin_message(1'b1, 8'h00);
		add_cookie(0);
		send_packet();

		// bad last cookie byte: options that follow are ignored
		begin_message(1'b1, 8'h00);
		add_cookie(3);
		add_option(OPT_LEASE, 4, -1);
		packet_bytes.push_back(OPT_END);
		send_packet();

		// every decoded option at value extremes, pads, empty and longest skipped
		// options, a repeat, the end option and trailing bytes that must be ignored
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		packet_bytes.push_back(OPT_PAD);
		add_option(OPT_MSGTYPE, 1, 8'h00);
		add_option(OPT_LEASE, 4, 8'hFF);
		add_option(OPT_MASK, 4, 8'h00);
		add_option(OPT_SERVER, 4, 8'hFF);
		add_option(8'd12, 0, -1);
		add_option(8'd250, 255, -1);
		packet_bytes.push_back(OPT_PAD);
		packet_bytes.push_back(OPT_PAD);
		add_option(OPT_MSGTYPE, 1, 8'hFF);
		add_option(OPT_LEASE, 4, 8'h00);
		packet_bytes.push_back(OPT_END);
		add_option(OPT_LEASE, 3, -1);
		send_packet();

		// wrong option size: first error wins, later ones are ignored
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		add_option(OPT_MASK, 4, -1);
		add_option(OPT_LEASE, 3, -1);
		add_option(OPT_MSGTYPE, 2, -1);
		packet_bytes.push_back(OPT_END);
		send_packet();

		// decoded option with zero length is a size error too
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		add_option(OPT_MSGTYPE, 0, -1);
		packet_bytes.push_back(OPT_END);
		send_packet();

		// end on an option code byte: truncated
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		add_option(OPT_SERVER, 4, -1);
		packet_bytes.push_back(OPT_MASK);
		send_packet();

		// end on an option length byte: truncated
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		packet_bytes.push_back(OPT_LEASE);
		packet_bytes.push_back(8'd4);
		send_packet();

		// end inside option data: truncated
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		add_option(8'd60, 6, -1);
		packet_bytes = packet_bytes[0:packet_bytes.size() - 3];
		send_packet();

		// end between options on a pad, no end option
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		add_option(OPT_MSGTYPE, 1, -1);
		packet_bytes.push_back(OPT_PAD);
		send_packet();

		// end on the end option itself
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		add_option(OPT_SERVER, 4, -1);
		packet_bytes.push_back(OPT_END);
		send_packet();

		drain_results();

		// long message: options keep decoding after the position counter saturates
		begin_message(1'b1, 8'h00);
		add_cookie(-1);
		while (packet_bytes.size() < 2150)
			add_random_options(1);
		add_option(OPT_SERVER, 4, -1);
		add_option(OPT_MSGTYPE, 1, -1);
		packet_bytes.push_back(OPT_END);
		send_packet();

		// random messages, mostly well formed so the option walk gets exercised
		run_start = bytes_sent;
		deep_packets = 0;
		while (bytes_sent - run_start < 1600 || deep_packets < 8) begin
			if (!quiet && bytes_sent - run_start >= 1400 && deep_packets >= 6) begin
				quiet = 1'b1;
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			kind = $urandom_range(0, 99);
			begin_message(1'b1, 8'h00);
			if (kind < 60) begin
				add_cookie(-1);
				add_random_options($urandom_range(0, 14));
				if ($urandom_range(0, 9) != 0)
					packet_bytes.push_back(OPT_END);
				repeat ($urandom_range(0, 6))
					packet_bytes.push_back(8'($urandom));
			end else if (kind < 75) begin
				// cut somewhere from inside the cookie into the option area
				add_cookie(-1);
				add_random_options($urandom_range(1, 14));
				cut = $urandom_range(HDR_BYTES + 1, packet_bytes.size());
				packet_bytes = packet_bytes[0:cut - 1];
			end else if (kind < 85) begin
				add_cookie(-1);
				add_random_options($urandom_range(0, 6));
				kind = $urandom_range(0, 12);
				add_option(pick_decoded_code(), kind, -1);
				add_random_options($urandom_range(0, 4));
				packet_bytes.push_back(OPT_END);
			end else if (kind < 92) begin
				add_cookie($urandom_range(0, 3));
				add_random_options($urandom_range(0, 4));
				packet_bytes.push_back(OPT_END);
			end else begin
				// short or noisy message, cut anywhere up to the cookie end
				spoil = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 3);
				add_cookie(spoil);
				cut = $urandom_range(1, HDR_BYTES + COOKIE_BYTES);
				packet_bytes = packet_bytes[0:cut - 1];
			end
			if (packet_bytes.size() > HDR_BYTES + COOKIE_BYTES)
				deep_packets++;
			send_packet();
			if (!quiet && $urandom_range(0, 29) == 0)
				drain_results();
		end

		// drop valid, wait out every predicted word, then watch for strays
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (board.mismatches == 0)
			$display("[dhcp_packet_parser] OK");
		else
			$display("[dhcp_packet_parser] ERROR");
		$finish;
	end

endmodule

/* files.f */
hdl/dpp_pkg.sv
hdl/dhcp_packet_parser.sv
bench/dpp_bench_pkg.sv
bench/dhcp_packet_parser_test.sv
